// ----- rtl/rbb_pkg.sv -----
// Shared types and constants for the row box blur.
// No dependencies; every other file imports this package.
`default_nettype none

package rbb_pkg;

	localparam int PIX_W     = 8;
	localparam int PIX_MAX   = 255;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	// Register indexes of the write port
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 1'b1;

	localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 11'd320;

	// What one accepted pixel asks of the burst emitter
	typedef struct packed {
		logic bypass; // send the raw pixel
		logic pre;    // first repeat the held row-end value
		logic main;   // send the filtered value
		logic extra;  // send the filtered value RADIUS more times
		logic hold;   // keep the filtered value for the next row-end burst
	} burst_t;

endpackage

`default_nettype wire

// ----- rtl/rbb_pix_if.sv -----
// Input channel of the row box blur: one luma pixel per word.
// Depends on rbb_pkg.
`default_nettype none

interface rbb_pix_if import rbb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ----- rtl/rbb_res_if.sv -----
// Result channel of the row box blur: one filtered pixel per word.
// Depends on rbb_pkg.
`default_nettype none

interface rbb_res_if import rbb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] blurred;
	logic             last_of_burst;

	modport source (output valid, output blurred, output last_of_burst, input ready);
	modport sink   (input valid, input blurred, input last_of_burst, output ready);
endinterface

`default_nettype wire

// ----- rtl/rbb_tap_cell.sv -----
// One cell of the window delay line: holds one pixel, hands it on when shifted.
// Depends on rbb_pkg.
`default_nettype none

module rbb_tap_cell import rbb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             shift,
	input  wire logic [PIX_W-1:0] d,
	output logic      [PIX_W-1:0] q
);

	logic [PIX_W-1:0] tap_q;

	// Clear on reset so the running sum starts consistent with the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift) begin
			tap_q <= d;
		end
	end

	assign q = tap_q;

endmodule

`default_nettype wire

// ----- rtl/rbb_scale.sv -----
// Reciprocal multiply stage: window sum times 1/(2*RADIUS+1) in fixed point,
// registered, then shifted and saturated. Depends on rbb_pkg.
`default_nettype none

module rbb_scale import rbb_pkg::*; #(
	parameter int RADIUS     = 1,
	parameter int SCALE_BITS = 16,
	parameter int SUM_W      = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [SUM_W-1:0] in_sum,
	input  wire logic [PIX_W-1:0] in_pixel,
	input  wire burst_t           in_flags,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [PIX_W-1:0] out_value,
	output burst_t                out_flags
);

	localparam int NTAPS = 2 * RADIUS + 1;
	localparam int MUL_W = SCALE_BITS;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam logic [MUL_W-1:0] MUL = MUL_W'(((64'd1 << SCALE_BITS) / NTAPS) + 64'd1);

	logic              valid_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [PIX_W-1:0]  pixel_s2;
	burst_t            flags_s2;
	logic [SUM_W-1:0]  mean;

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_s2  <= PROD_W'(in_sum) * PROD_W'(MUL);
			pixel_s2 <= in_pixel;
			flags_s2 <= in_flags;
		end
	end

	// Drop the fraction, clamp to the pixel range
	assign mean = prod_s2[PROD_W-1:SCALE_BITS];

	always_comb begin
		if (flags_s2.bypass) begin
			out_value = pixel_s2;
		end else if (mean > SUM_W'(PIX_MAX)) begin
			out_value = PIX_W'(PIX_MAX);
		end else begin
			out_value = mean[PIX_W-1:0];
		end
	end

	assign out_valid = valid_s2;
	assign out_flags = flags_s2;

endmodule

`default_nettype wire

// ----- rtl/rbb_emit.sv -----
// Burst emitter: turns one entry into one to RADIUS+1 result words, keeps the
// held row-end value. Depends on rbb_pkg and rbb_res_if.
`default_nettype none

module rbb_emit import rbb_pkg::*; #(
	parameter int RADIUS = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [PIX_W-1:0] in_value,
	input  wire burst_t           in_flags,
	rbb_res_if.source             results
);

	localparam int CNT_W = $clog2(RADIUS + 2);

	logic [CNT_W-1:0] pre_cnt_q;
	logic [CNT_W-1:0] main_cnt_q;
	logic [PIX_W-1:0] value_q;
	logic [PIX_W-1:0] tail_q;
	logic             busy;
	logic             last_word;
	logic             load;

	assign busy      = (pre_cnt_q != '0) || (main_cnt_q != '0);
	assign last_word = ((pre_cnt_q == CNT_W'(1)) && (main_cnt_q == '0)) ||
	                   ((pre_cnt_q == '0) && (main_cnt_q == CNT_W'(1)));
	assign in_ready  = !busy || (results.ready && last_word);
	assign load      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_cnt_q  <= '0;
			main_cnt_q <= '0;
			tail_q     <= '0;
		end else if (load) begin
			pre_cnt_q <= in_flags.pre ? CNT_W'(RADIUS) : '0;
			if (!in_flags.main) begin
				main_cnt_q <= '0;
			end else if (in_flags.extra) begin
				main_cnt_q <= CNT_W'(RADIUS + 1);
			end else begin
				main_cnt_q <= CNT_W'(1);
			end
			if (in_flags.hold) begin
				tail_q <= in_value;
			end
		end else if (busy && results.ready) begin
			// Drain the held copies first, then the filtered value
			if (pre_cnt_q != '0) begin
				pre_cnt_q <= pre_cnt_q - CNT_W'(1);
			end else begin
				main_cnt_q <= main_cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= in_value;
		end
	end

	assign results.valid         = busy;
	assign results.blurred       = (pre_cnt_q != '0) ? tail_q : value_q;
	assign results.last_of_burst = last_word;

endmodule

`default_nettype wire

// ----- rtl/row_box_blur_core.sv -----
// Row box blur: horizontal (2*RADIUS+1)-tap mean over raster luma rows.
// A pixel reaches the result channel through stage 1, stage 2 and the emitter.
// Throughput: one pixel per cycle unless results stall; a pixel that yields
// several words holds the input in the burst emitter (row start and row end).
// Reset: window, running sum, column and held row-end value clear to zero,
// row_width to 320, bypass off, pipeline empty.
// Depends on rbb_pkg, rbb_pix_if, rbb_res_if, rbb_tap_cell, rbb_scale, rbb_emit.
`default_nettype none

module row_box_blur_core import rbb_pkg::*; #(
	parameter int RADIUS     = 1,
	parameter int SCALE_BITS = 16,
	parameter int MAX_WIDTH  = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	rbb_pix_if.sink                   pixels,
	rbb_res_if.source                 results
);

	localparam int NTAPS = 2 * RADIUS + 1;
	localparam int SUM_W = $clog2(NTAPS * PIX_MAX + 1);
	localparam int COL_W = $clog2(MAX_WIDTH);
	// Wide enough for the row width register, the column and the tap count
	localparam int EXT_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

	// Configuration
	logic [CFG_W-1:0] row_width_q;
	logic             bypass_q;

	// Row state
	logic [SUM_W-1:0] sum_q;
	logic [COL_W-1:0] col_q;
	logic             pend_q;    // row-end copies still owed to the next row

	// Window chain
	logic [PIX_W-1:0] tap [NTAPS];

	// Stage 1 registers
	logic             valid_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [PIX_W-1:0] pixel_s1;
	burst_t           flags_s1;

	// Handshake
	logic in_ready;
	logic accept;
	logic filt_accept;
	logic s2_ready;
	logic s2_valid;
	logic [PIX_W-1:0] s2_value;
	burst_t           s2_flags;
	logic emit_ready;

	// Decode of the current pixel
	logic [EXT_W-1:0] width_ext;
	logic [EXT_W-1:0] width_eff;
	logic [COL_W-1:0] last_col;
	logic [EXT_W-1:0] col_ext;
	logic             in_body;
	logic             row_first;
	logic             row_end;
	logic [SUM_W-1:0] sum_next;
	burst_t           flags_next;
	logic             has_words;

	//------------------------------------------------------------------
	// Configuration port: a write takes effect at the edge where wr_en
	// is high; the next accepted pixel sees the new value
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
			bypass_q    <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROW_WIDTH: row_width_q <= wr_data;
				REG_BYPASS:    bypass_q    <= wr_data[0];
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Input handshake: stage 1 takes a word whenever it can move on
	//------------------------------------------------------------------
	assign in_ready     = !valid_s1 || s2_ready;
	assign pixels.ready = in_ready;
	assign accept       = pixels.valid && in_ready;
	assign filt_accept  = accept && !bypass_q;

	//------------------------------------------------------------------
	// Window: a chain of tap cells, shifted once per filtered pixel.
	// The oldest pixel leaves the running sum as the new one enters.
	//------------------------------------------------------------------
	for (genvar i = 0; i < NTAPS; i++) begin : g_tap
		if (i == 0) begin : g_head
			rbb_tap_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (filt_accept),
				.d      (pixels.pixel),
				.q      (tap[i])
			);
		end else begin : g_body
			rbb_tap_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (filt_accept),
				.d      (tap[i-1]),
				.q      (tap[i])
			);
		end
	end

	assign sum_next = sum_q - SUM_W'(tap[NTAPS-1]) + SUM_W'(pixels.pixel);

	//------------------------------------------------------------------
	// Row position decode. The width is clamped to [NTAPS, MAX_WIDTH].
	// A column already at or past the last one ends the row, which covers
	// a width lowered in the middle of a row.
	//------------------------------------------------------------------
	always_comb begin
		width_ext = EXT_W'(row_width_q);
		if (width_ext < EXT_W'(NTAPS)) begin
			width_eff = EXT_W'(NTAPS);
		end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
			width_eff = EXT_W'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		last_col = COL_W'(width_eff - EXT_W'(1));
		col_ext  = EXT_W'(col_q);
		in_body   = col_ext >= EXT_W'(2 * RADIUS);
		row_first = col_ext == EXT_W'(2 * RADIUS);
		row_end   = in_body && (col_q >= last_col);

		flags_next        = '0;
		flags_next.bypass = bypass_q;
		if (bypass_q) begin
			flags_next.main = 1'b1;
		end else begin
			flags_next.pre  = pend_q;
			flags_next.main = in_body;
			// Leading copies at the first full window, trailing copies at
			// row end; the narrowest row defers its trailing copies.
			flags_next.extra = row_first || (row_end && !row_first);
			flags_next.hold  = row_end && row_first;
		end
		has_words = flags_next.main || flags_next.pre;
	end

	//------------------------------------------------------------------
	// Row state: advance on every filtered pixel, hold on bypass words
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			col_q  <= '0;
			pend_q <= 1'b0;
		end else if (filt_accept) begin
			sum_q  <= sum_next;
			pend_q <= flags_next.hold;
			if (row_end) begin
				col_q <= '0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	//------------------------------------------------------------------
	// Stage 1: drop pixels that yield no word (window still filling)
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && has_words;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1   <= sum_next;
			pixel_s1 <= pixels.pixel;
			flags_s1 <= flags_next;
		end
	end

	//------------------------------------------------------------------
	// Stage 2: reciprocal multiply and saturation
	//------------------------------------------------------------------
	rbb_scale #(
		.RADIUS     (RADIUS),
		.SCALE_BITS (SCALE_BITS),
		.SUM_W      (SUM_W)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (s2_ready),
		.in_sum    (sum_s1),
		.in_pixel  (pixel_s1),
		.in_flags  (flags_s1),
		.out_valid (s2_valid),
		.out_ready (emit_ready),
		.out_value (s2_value),
		.out_flags (s2_flags)
	);

	//------------------------------------------------------------------
	// Stage 3: burst emitter drives the result channel from registers
	//------------------------------------------------------------------
	rbb_emit #(
		.RADIUS (RADIUS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s2_valid),
		.in_ready (emit_ready),
		.in_value (s2_value),
		.in_flags (s2_flags),
		.results  (results)
	);

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	// Owed row-end copies exist only right after a row has closed
	a_pend_at_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (col_q == '0))
		else $error("row-end copies pending away from column zero");

	// The next filtered pixel always pays off the owed copies
	a_pend_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(filt_accept && pend_q) |=> !pend_q)
		else $error("owed row-end copies not consumed");

	// A stalled stage 1 keeps its word
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_ready) |=> (valid_s1 && $stable(sum_s1) && $stable(flags_s1)))
		else $error("stage 1 word lost while stalled");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for row_box_blur_core: random and directed pixel rows,
// checked word by word against an in-bench running-sum blur predictor.
// Depends on rbb_pkg, rbb_pix_if, rbb_res_if and the core itself.
`default_nettype none

module tb_top;
	import rbb_pkg::*;

	localparam int RADIUS     = 1;
	localparam int SCALE_BITS = 16;
	localparam int MAX_WIDTH  = 1024;
	localparam int NTAPS      = 2 * RADIUS + 1;

	// Fixed-point reciprocal of the tap count
	localparam longint unsigned RECIP = (64'd1 << SCALE_BITS) / NTAPS + 1;

	// Cycles to let the pipeline settle once nothing is expected any more
	localparam int DRAIN_CYCLES = 8;
	// Long receiver hold-off, enough to fill the core and stall its input
	localparam int HOLD_CYCLES  = 400;
	// Cycles with no word moving on either channel before giving up
	localparam int STALL_LIMIT  = 4000;

	typedef struct packed {
		logic [PIX_W-1:0] blurred;
		logic             last_of_burst;
	} blur_word_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	rbb_pix_if pix_ch ();
	rbb_res_if res_ch ();

	row_box_blur_core #(
		.RADIUS    (RADIUS),
		.SCALE_BITS(SCALE_BITS),
		.MAX_WIDTH (MAX_WIDTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.pixels  (pix_ch),
		.results (res_ch)
	);

	always #5 clk = ~clk;

	// Pixels waiting to be offered, and filtered words waiting to come out
	logic [PIX_W-1:0] pix_queue[$];
	blur_word_t       blur_expect[$];

	// Idle rates in percent, set per phase by the stimulus process
	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;

	// Bump to request one long receiver hold-off
	int hold_req_count = 0;
	int hold_seen;
	int hold_left;

	int fail_count = 0;
	int word_count = 0;
	int stall_cycles;

	// Predictor copy of the registers
	logic [CFG_W-1:0] cfg_row_width;
	logic             cfg_bypass;

	// Predictor copy of the filter state
	logic [PIX_W-1:0] win[NTAPS];
	int unsigned      win_sum;
	int unsigned      col;
	logic             tail_held;
	logic [PIX_W-1:0] tail_val;

	function automatic int unsigned clamp_width(input logic [CFG_W-1:0] w);
		int unsigned cw;
		cw = 32'(w);
		if (cw < NTAPS) cw = NTAPS;
		if (cw > MAX_WIDTH) cw = MAX_WIDTH;
		return cw;
	endfunction

	function automatic logic [PIX_W-1:0] scale_sum(input int unsigned s);
		longint unsigned v;
		v = (longint'(s) * RECIP) >> SCALE_BITS;
		// saturate: a product above full scale clips to white
		if (v > PIX_MAX) v = PIX_MAX;
		return v[PIX_W-1:0];
	endfunction

	// Advance the filter state by one accepted pixel and queue the words it causes
	task automatic blur_pixel(input logic [PIX_W-1:0] pix);
		blur_word_t  burst[$];
		int unsigned w;
		int unsigned c;
		int unsigned n;
		logic [PIX_W-1:0] v;
		if (cfg_bypass) begin
			// pass through; leave window, sum, column and held tail alone
			burst.push_back('{blurred: pix, last_of_burst: 1'b0});
		end else begin
			// flush the row-end copies held back from a narrowest row
			if (tail_held) begin
				for (int i = 0; i < RADIUS; i++)
					burst.push_back('{blurred: tail_val, last_of_burst: 1'b0});
				tail_held = 1'b0;
			end
			win_sum = win_sum - win[NTAPS-1] + pix;
			for (int i = NTAPS - 1; i > 0; i--)
				win[i] = win[i-1];
			win[0] = pix;
			w = clamp_width(cfg_row_width);
			c = col;
			if (c >= 2 * RADIUS) begin
				v = scale_sum(win_sum);
				// first full window also repeats into the leading edge columns
				n = (c == 2 * RADIUS) ? RADIUS + 1 : 1;
				for (int i = 0; i < n; i++)
					burst.push_back('{blurred: v, last_of_burst: 1'b0});
				if (c >= w - 1) begin
					if (c == 2 * RADIUS) begin
						// narrowest row: hold the tail for the next pixel
						tail_held = 1'b1;
						tail_val  = v;
					end else begin
						for (int i = 0; i < RADIUS; i++)
							burst.push_back('{blurred: v, last_of_burst: 1'b0});
					end
					col = 0;
				end else begin
					col = c + 1;
				end
			end else begin
				col = c + 1;
			end
		end
		if (burst.size() > 0) burst[$].last_of_burst = 1'b1;
		foreach (burst[i]) blur_expect.push_back(burst[i]);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("tb_top: word %0d: %s mismatch, got %0d expected %0d",
			word_count, what, got, want);
		fail_count++;
	endtask

	// Track register writes at the edge where the core takes them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_row_width <= ROW_WIDTH_RESET;
			cfg_bypass    <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROW_WIDTH: cfg_row_width <= wr_data;
				REG_BYPASS:    cfg_bypass    <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Pixel driver: predict on acceptance, then offer the next word or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
			pix_ch.pixel <= '0;
			for (int i = 0; i < NTAPS; i++) win[i] = '0;
			win_sum   = 0;
			col       = 0;
			tail_held = 1'b0;
			tail_val  = '0;
		end else begin
			if (pix_ch.valid && pix_ch.ready)
				blur_pixel(pix_ch.pixel);
			// hold an offered word until it is taken
			if (!pix_ch.valid || pix_ch.ready) begin
				if (pix_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					pix_ch.valid <= 1'b1;
					pix_ch.pixel <= pix_queue.pop_front();
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random back-pressure plus requested long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_seen    <= 0;
			hold_left    <= 0;
		end else if (hold_seen != hold_req_count) begin
			hold_seen    <= hold_req_count;
			hold_left    <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// Result monitor: compare each taken word with the oldest expectation
	always @(posedge clk) begin : result_check
		blur_word_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (blur_expect.size() == 0) begin
				report_mismatch("unexpected word", int'(res_ch.blurred), -1);
			end else begin
				want = blur_expect.pop_front();
				if (res_ch.blurred !== want.blurred)
					report_mismatch("blurred", int'(res_ch.blurred),
						int'(want.blurred));
				if (res_ch.last_of_burst !== want.last_of_burst)
					report_mismatch("last_of_burst", int'(res_ch.last_of_burst),
						int'(want.last_of_burst));
			end
			word_count <= word_count + 1;
		end
	end

	// Watchdog: count cycles in which no word moves on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("tb_top: timeout after %0d idle cycles", STALL_LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

	// Drain: wait until nothing is offered or expected, then let the pipeline settle
	task automatic wait_idle();
		do @(negedge clk);
		while (pix_queue.size() != 0 || pix_ch.valid || blur_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en    <= 1'b0;
		@(negedge clk);
	endtask

	// Queue n random pixels, weighted toward black and white
	task automatic push_pixels(input int n);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 7);
			if (sel == 0)      pix_queue.push_back('0);
			else if (sel == 1) pix_queue.push_back(PIX_MAX[PIX_W-1:0]);
			else               pix_queue.push_back(PIX_W'($urandom_range(0, PIX_MAX)));
		end
	endtask

	initial begin : stimulus
		int sel;
		logic [CFG_W-1:0] w;
		// drive every input to a known value before the first edge
		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_index     = '0;
		wr_data      = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		res_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// Directed: narrowest row, so the row-end copies are held to the next row
		write_reg(REG_ROW_WIDTH, 11'd3);
		write_reg(REG_BYPASS, 11'd0);
		pix_queue.push_back(8'd255);
		pix_queue.push_back(8'd255);
		pix_queue.push_back(8'd255);
		pix_queue.push_back(8'd0);
		pix_queue.push_back(8'd0);
		pix_queue.push_back(8'd0);
		pix_queue.push_back(8'd255);
		pix_queue.push_back(8'd0);
		pix_queue.push_back(8'd255);
		wait_idle();
		// width below the tap count acts as the narrowest row
		write_reg(REG_ROW_WIDTH, 11'd0);
		pix_queue.push_back(8'd128);
		pix_queue.push_back(8'd1);
		pix_queue.push_back(8'd254);
		wait_idle();
		// leave a five-wide row mid-row, then shrink it: the next pixel ends it
		write_reg(REG_ROW_WIDTH, 11'd5);
		pix_queue.push_back(8'd10);
		pix_queue.push_back(8'd20);
		pix_queue.push_back(8'd30);
		pix_queue.push_back(8'd40);
		wait_idle();
		write_reg(REG_ROW_WIDTH, 11'd3);
		pix_queue.push_back(8'd200);
		pix_queue.push_back(8'd100);
		wait_idle();
		// bypass passes pixels raw; junk in the upper data bits is ignored
		write_reg(REG_BYPASS, 11'h001);
		pix_queue.push_back(8'd0);
		pix_queue.push_back(8'd255);
		pix_queue.push_back(8'hAA);
		pix_queue.push_back(8'h55);
		wait_idle();
		write_reg(REG_BYPASS, 11'h7FE);
		pix_queue.push_back(8'd77);
		pix_queue.push_back(8'd255);
		wait_idle();

		// Random phases: receiver sparse first, then sender sparse, then no idling
		for (int ph = 0; ph < 12; ph++) begin
			wait_idle();
			sender_idle_pct   = (ph < 4) ? 8 : (ph < 8) ? 52 : 0;
			receiver_idle_pct = (ph < 4) ? 52 : (ph < 8) ? 8 : 0;
			sel = $urandom_range(0, 9);
			if (sel == 0)      w = CFG_W'($urandom_range(0, 2));
			else if (sel == 1) w = 11'd3;
			else               w = CFG_W'($urandom_range(4, 24));
			write_reg(REG_ROW_WIDTH, w);
			write_reg(REG_BYPASS,
				{CFG_W'($urandom_range(0, 1023)) << 1} | CFG_W'($urandom_range(0, 4) == 0));
			if (ph == 2 || ph == 9) begin
				// hold off the receiver while the sender keeps offering
				hold_req_count = hold_req_count + 1;
				push_pixels(32);
			end else if (ph == 5) begin
				// pause the sender until every expected word is out, then resume
				push_pixels(16);
				do @(negedge clk);
				while (pix_queue.size() != 0 || pix_ch.valid || blur_expect.size() != 0);
				push_pixels(16);
			end else begin
				push_pixels(32);
			end
		end

		// Wide rows: exact maximum, then an over-range width held in mid-row
		wait_idle();
		write_reg(REG_BYPASS, 11'd0);
		write_reg(REG_ROW_WIDTH, 11'd1024);
		push_pixels(40);
		wait_idle();
		write_reg(REG_ROW_WIDTH, 11'd2047);
		push_pixels(200);
		wait_idle();
		// back to a short row, likely cutting the current one
		write_reg(REG_ROW_WIDTH, 11'd7);
		sender_idle_pct   = 20;
		receiver_idle_pct = 20;
		push_pixels(40);

		wait_idle();
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
